// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_t;

	typedef struct packed {
		logic              last_blk;
		logic [15:0][31:0] words;
	} blk_t;

	localparam logic       KIND_APPEND = 1'b0;
	localparam logic       KIND_FINISH = 1'b1;
	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [5:0] LEN_OFFSET  = 6'd56;
	localparam logic [5:0] LAST_SLOT   = 6'd63;

	localparam logic [7:0][31:0] INIT_VEC = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam logic [63:0][31:0] ROUND_K = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

endpackage

// ----- hw/rtl/sha_front.sv -----
// ----------------------------------------------------------------------------
// sha_front
// packs message bytes into 64-byte blocks and generates the padding
// ----------------------------------------------------------------------------
module sha_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  sha_pkg::in_t  item,
	output logic          blk_valid,
	input  logic          blk_stall,
	output sha_pkg::blk_t blk
);

	logic [15:0][3:0][7:0] words_q;
	logic [5:0]            fill_q;
	logic [60:0]           count_q;
	logic [7:0][7:0]       len_q;
	logic                  pad_q;
	logic                  lenph_q;
	logic                  pend_q;
	logic                  pend_last_q;

	logic       acc;
	logic       we;
	logic       pad_len;
	logic [7:0] wbyte;

	assign item_stall = pad_q || pend_q;
	assign acc        = item_valid && !item_stall;
	assign pad_len    = pad_q && (lenph_q || fill_q == sha_pkg::LEN_OFFSET);

	always_comb begin
		we    = 1'b0;
		wbyte = item.data_byte;
		if (pad_q && !pend_q) begin
			we    = 1'b1;
			wbyte = pad_len ? len_q[~fill_q[2:0]] : 8'h00;
		end else if (acc) begin
			we    = 1'b1;
			wbyte = (item.kind == sha_pkg::KIND_FINISH) ? sha_pkg::PAD_BYTE : item.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			words_q[fill_q[5:2]][~fill_q[1:0]] <= wbyte;
		end
		if (acc && item.kind == sha_pkg::KIND_FINISH) begin
			len_q <= {count_q, 3'b000};
		end
		if (we && fill_q == sha_pkg::LAST_SLOT) begin
			pend_last_q <= pad_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			pad_q   <= 1'b0;
			lenph_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q && !blk_stall) begin
				pend_q <= 1'b0;
			end
			if (we) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == sha_pkg::LAST_SLOT) begin
					pend_q <= 1'b1;
				end
			end
			if (pad_q && we && pad_len) begin
				lenph_q <= 1'b1;
				if (fill_q == sha_pkg::LAST_SLOT) begin
					pad_q   <= 1'b0;
					lenph_q <= 1'b0;
				end
			end
			if (acc) begin
				if (item.kind == sha_pkg::KIND_FINISH) begin
					pad_q   <= 1'b1;
					count_q <= '0;
				end else begin
					count_q <= count_q + 61'd1;
				end
			end
		end
	end

	assign blk_valid    = pend_q;
	assign blk.last_blk = pend_last_q;
	assign blk.words    = words_q;

endmodule

// ----- hw/rtl/sha_blkq.sv -----
// ----------------------------------------------------------------------------
// sha_blkq
// two-entry block queue between packer and compression core
// ----------------------------------------------------------------------------
module sha_blkq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_stall,
	input  sha_pkg::blk_t push_data,
	output logic          pop_valid,
	input  logic          pop_take,
	output sha_pkg::blk_t pop_data
);

	sha_pkg::blk_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_stall = (cnt_q == 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && pop_take;
	assign pop_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/sha_core.sv -----
// ----------------------------------------------------------------------------
// sha_core
// 64-round compression, one round per cycle, and digest output
// ----------------------------------------------------------------------------
module sha_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          blk_valid,
	output logic          blk_take,
	input  sha_pkg::blk_t blk,
	output logic          result_valid,
	input  logic          result_stall,
	output sha_pkg::out_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RND  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        st_q;
	logic [5:0]        rnd_q;
	logic [2:0]        idx_q;
	logic              last_q;
	logic [7:0][31:0]  cv_q;
	logic [7:0][31:0]  v_q;
	logic [15:0][31:0] win_q;
	logic              res_vld_q;
	sha_pkg::out_t     res_q;

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] s1, ch, s0, maj, t1, t2, w16, ws0, ws1;

	always_comb begin
		a   = v_q[0];
		b   = v_q[1];
		c   = v_q[2];
		d   = v_q[3];
		e   = v_q[4];
		f   = v_q[5];
		g   = v_q[6];
		h   = v_q[7];
		s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		ch  = (e & f) ^ (~e & g);
		t1  = h + s1 + ch + sha_pkg::ROUND_K[rnd_q] + win_q[0];
		s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		maj = (a & b) ^ (a & c) ^ (b & c);
		t2  = s0 + maj;
		ws0 = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
			^ {3'b000, win_q[1][31:3]};
		ws1 = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
			^ {10'd0, win_q[14][31:10]};
		w16 = win_q[0] + ws0 + win_q[9] + ws1;
	end

	assign blk_take     = (st_q == ST_IDLE);
	assign result_valid = res_vld_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				v_q    <= cv_q;
				win_q  <= blk.words;
				last_q <= blk.last_blk;
			end
			ST_RND: begin
				v_q   <= {g, f, e, d + t1, c, b, a, t1 + t2};
				win_q <= {w16, win_q[15:1]};
			end
			ST_ADD, ST_EMIT: begin
			end
			default: begin
			end
		endcase
		if (st_q == ST_EMIT && (!res_vld_q || !result_stall)) begin
			res_q.digest_word <= cv_q[idx_q];
			res_q.word_index  <= idx_q;
			res_q.last_word   <= (idx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			rnd_q     <= '0;
			idx_q     <= '0;
			cv_q      <= sha_pkg::INIT_VEC;
			res_vld_q <= 1'b0;
		end else begin
			if (res_vld_q && !result_stall) begin
				res_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (blk_valid) begin
						st_q <= ST_RND;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= cv_q[i] + v_q[i];
					end
					idx_q <= '0;
					st_q  <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!res_vld_q || !result_stall) begin
						res_vld_q <= 1'b1;
						idx_q     <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							cv_q <= sha_pkg::INIT_VEC;
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// item channel: one transfer per message byte (kind append) or one finish
// transfer that closes the message. append bytes are taken one per cycle;
// when a 64-byte block completes, the packer stalls the item channel while it
// pushes the block into a two-entry queue, longer while that queue is full.
// the core compresses a block in 64 rounds, one per cycle, plus load and
// chaining-value add, so long messages sustain a byte rate set by the single
// round unit.
// finish: the packer generates 0x80, zero fill and the 64-bit length one byte
// per cycle while no completed block waits to be pushed, stalling the item
// channel meanwhile.
// result channel: eight transfers, word 0 first, last_word on word 7,
// from an output register; a stalled result holds and the core waits.
// after the eighth word the chaining value returns to the initial vector.
// reset clears all control state and loads the initial vector.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  sha_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output sha_pkg::out_t result
);

	logic          fb_valid;
	logic          fb_stall;
	sha_pkg::blk_t fb_blk;
	logic          qb_valid;
	logic          qb_take;
	sha_pkg::blk_t qb_blk;

	sha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.blk_valid  (fb_valid),
		.blk_stall  (fb_stall),
		.blk        (fb_blk)
	);

	sha_blkq u_blkq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fb_valid),
		.push_stall (fb_stall),
		.push_data  (fb_blk),
		.pop_valid  (qb_valid),
		.pop_take   (qb_take),
		.pop_data   (qb_blk)
	);

	sha_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.blk_valid    (qb_valid),
		.blk_take     (qb_take),
		.blk          (qb_blk),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- sim/sha256_stream_hasher_top_test.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_test
// drives random and directed byte streams with finish transfers into the
// hasher, computes each expected digest with a local sha-256 model and
// checks every digest word transfer in order, under varying idle and stall
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_test;

	class digest_board;
		logic [7:0][31:0]   chain;
		logic [7:0]         buffer [64];
		int unsigned        fill;
		logic [60:0]        msg_len;
		sha_pkg::out_t      pending [$];
		int                 errors;

		function new();
			chain = sha_pkg::INIT_VEC;
			fill = 0;
			msg_len = '0;
			errors = 0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int r);
			return (x >> r) | (x << (32 - r));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
			for (int i = 0; i < 8; i++)
				v[i] = chain[i];
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + w[i];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void add_byte(logic [7:0] b);
			buffer[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		function void note_item(sha_pkg::in_t it);
			logic [63:0] bits;
			sha_pkg::out_t o;
			if (it.kind == sha_pkg::KIND_APPEND) begin
				add_byte(it.data_byte);
				msg_len = msg_len + 61'd1;
				return;
			end
			bits = {msg_len, 3'b000};
			add_byte(sha_pkg::PAD_BYTE);
			while (fill != sha_pkg::LEN_OFFSET)
				add_byte(8'h00);
			for (int i = 0; i < 8; i++)
				add_byte(bits[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				o.digest_word = chain[i];
				o.word_index = 3'(i);
				o.last_word = (i == 7);
				pending.push_back(o);
			end
			chain = sha_pkg::INIT_VEC;
			fill = 0;
			msg_len = '0;
		endfunction

		function void check_result(sha_pkg::out_t got);
			sha_pkg::out_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h idx %0d last %0b", $time,
					got.digest_word, got.word_index, got.last_word);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.digest_word !== exp_r.digest_word) begin
				$display("%0t: digest_word expected %h actual %h", $time,
					exp_r.digest_word, got.digest_word);
				errors++;
			end
			if (got.word_index !== exp_r.word_index) begin
				$display("%0t: word_index expected %0d actual %0d", $time,
					exp_r.word_index, got.word_index);
				errors++;
			end
			if (got.last_word !== exp_r.last_word) begin
				$display("%0t: last_word expected %0b actual %0b", $time,
					exp_r.last_word, got.last_word);
				errors++;
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	sha_pkg::in_t   item = '0;
	logic           result_valid;
	logic           result_stall = 1'b0;
	sha_pkg::out_t  result;

	digest_board board = new();
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_off = 0;

	sha256_stream_hasher_top u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #5 clk = ~clk;

	// result side: stall pattern and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				board.check_result(result);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_item(logic k, logic [7:0] b);
		sha_pkg::in_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		it.kind = k;
		it.data_byte = b;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		board.note_item(it);
	endtask

	task automatic send_message(int n, int mode);
		for (int i = 0; i < n; i++)
			case (mode)
				0: send_item(sha_pkg::KIND_APPEND, 8'($urandom));
				1: send_item(sha_pkg::KIND_APPEND, 8'h00);
				default: send_item(sha_pkg::KIND_APPEND, 8'hff);
			endcase
		send_item(sha_pkg::KIND_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int sent;
		int n;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0)
				n = $urandom_range(130);
			else
				n = $urandom_range(60);
			if (n > count - sent - 1)
				n = count - sent - 1;
			send_message(n, 0);
			sent += n + 1;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty message, pad edge lengths, all-zero and all-ones bytes
		send_message(0, 0);
		send_message(1, 1);
		send_message(3, 2);
		send_item(sha_pkg::KIND_FINISH, 8'hff);
		send_message(2, 0);
		drain();
		send_message(55, 0);
		send_message(56, 2);
		send_message(64, 1);
		drain();
		send_idle_pct = 0; recv_stall_pct = 0;
		random_phase(50);
		drain();
		send_idle_pct = 73; recv_stall_pct = 0;
		random_phase(40);
		drain();
		send_idle_pct = 0; recv_stall_pct = 73;
		random_phase(50);
		drain();
		send_idle_pct = 33; recv_stall_pct = 33;
		random_phase(34);
		// long hold-off of the result side while items keep coming
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_off = 600;
		send_message(3, 0);
		send_message(2, 0);
		random_phase(40);
		drain();
		wait (board.pending.size() == 0);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
